/* rtl/cwep_pkg.sv */
// Shared types and constants for the contention window event picker.
`timescale 1ns / 1ps

package cwep_pkg;

    localparam int MAX_CANDIDATES = 16;
    localparam int NEIGHBOR_SLOTS = 11;
    localparam int IDX_W          = $clog2(MAX_CANDIDATES);
    localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);

    localparam logic [31:0] WINDOW_RESET = 32'd45000;
    localparam logic [63:0] ANCHOR_NONE  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_CANDIDATES);

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [63:0] anchor_time;
        logic [1:0]  priority_class;
        logic        neighbor_valid;
        logic [3:0]  neighbor_index;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [2:0]  chosen_kind;
        logic [63:0] chosen_anchor;
        logic [1:0]  chosen_priority;
        logic        chosen_neighbor_valid;
        logic [3:0]  chosen_neighbor_index;
    } out_item_t;

    // One stored candidate: anchor plus tag.
    typedef struct packed {
        logic [63:0] anchor;
        logic [2:0]  kind;
        logic [1:0]  prio;
        logic        nbr_valid;
        logic [3:0]  nbr_index;
    } cand_t;

endpackage

/* rtl/contention_window_event_picker.sv */
// Top level of the contention window event picker.
// Loading: one candidate item per cycle, s_ready high while collecting a round.
// Selection: after the last item of a round, two passes run over the candidate
//   memory, then the winner is emitted once the output register is free; an
//   empty round skips both passes and goes straight to emit.
// Reset (aresetn, synchronous, active low): round empty, no result pending,
//   window back to 45000 us. Candidate memory contents are not cleared.
`timescale 1ns / 1ps

module contention_window_event_picker (
    input  logic                aclk,
    input  logic                aresetn,
    // candidate items
    input  logic                s_valid,
    output logic                s_ready,
    input  cwep_pkg::in_item_t  s_data,
    // result items
    output logic                m_valid,
    input  logic                m_ready,
    output cwep_pkg::out_item_t m_data,
    // contention window register
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data
);
    import cwep_pkg::*;

    // LOAD:      take candidates, write each wanted one to the next free entry.
    // SCAN_MIN:  first pass, find the earliest anchor (first one wins a tie).
    // SCAN_PICK: second pass in load order, let priority override inside the window.
    // EMIT:      hand the winner to the output register once it is free.
    typedef enum logic [1:0] {
        LOAD,
        SCAN_MIN,
        SCAN_PICK,
        EMIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;   // candidates stored this round
    logic [CNT_W-1:0] iss_reg;     // next entry to read in the current pass
    logic             rvld_reg;    // read data returns this cycle
    logic             first_reg;   // next returned entry is the first of the pass
    cand_t            best_reg;    // current choice, held whole so no re-read is needed
    logic [31:0]      window_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    logic             s_fire;
    logic             store;
    logic [CNT_W-1:0] count_after;
    cand_t            wr_cand;
    logic             rd_en;
    cand_t            rd_cand;
    logic [64:0]      win_limit;
    logic             in_window;
    logic             take_min;
    logic             take_pick;
    logic             pass_done;
    logic             out_free;

    // Accept only while collecting; the scan never overlaps a write, which keeps
    // the memory free of read/write hazards on the same entry.
    assign s_ready = (state_reg == LOAD);
    assign s_fire  = s_valid && s_ready;

    // Drop unwanted anchors and anything beyond capacity.
    assign store       = s_fire && (s_data.anchor_time != ANCHOR_NONE) && (count_reg < CNT_FULL);
    assign count_after = store ? count_reg + CNT_W'(1) : count_reg;

    always_comb begin
        wr_cand.anchor    = s_data.anchor_time;
        wr_cand.kind      = s_data.event_kind;
        wr_cand.prio      = s_data.priority_class;
        wr_cand.nbr_valid = s_data.neighbor_valid;
        // Store the slot as zero when the candidate has no neighbor.
        wr_cand.nbr_index = s_data.neighbor_valid ? s_data.neighbor_index : 4'd0;
    end

    assign rd_en = ((state_reg == SCAN_MIN) || (state_reg == SCAN_PICK)) &&
                   (iss_reg < count_reg);

    cwep_cand_mem u_mem (
        .aclk    (aclk),
        .wr_en   (store),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_cand),
        .rd_en   (rd_en),
        .rd_addr (iss_reg[IDX_W-1:0]),
        .rd_data (rd_cand)
    );

    // Window test at 65 bits: a sum past 2^64-1 admits every anchor.
    assign win_limit = {1'b0, best_reg.anchor} + {33'd0, window_reg};
    assign in_window = ({1'b0, rd_cand.anchor} <= win_limit);

    assign take_min  = first_reg || (rd_cand.anchor < best_reg.anchor);
    assign take_pick = in_window &&
                       ((rd_cand.prio > best_reg.prio) ||
                        ((rd_cand.prio == best_reg.prio) &&
                         (rd_cand.anchor < best_reg.anchor)));

    // Last data of the pass is in hand when every entry has been issued.
    assign pass_done = rvld_reg && (iss_reg == count_reg);
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= LOAD;
            count_reg   <= '0;
            iss_reg     <= '0;
            rvld_reg    <= 1'b0;
            first_reg   <= 1'b0;
            window_reg  <= WINDOW_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
            end
            // Raise valid when the winner moves out, drop it once the item is taken.
            if ((state_reg == EMIT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            rvld_reg <= rd_en;
            if (rd_en) begin
                iss_reg <= iss_reg + CNT_W'(1);
            end

            unique case (state_reg)
                LOAD: begin
                    count_reg <= count_after;
                    if (s_fire && s_data.last) begin
                        iss_reg   <= '0;
                        first_reg <= 1'b1;
                        // Skip both passes when nothing was stored.
                        state_reg <= (count_after == '0) ? EMIT : SCAN_MIN;
                    end
                end
                SCAN_MIN: begin
                    if (rvld_reg) begin
                        first_reg <= 1'b0;
                        if (take_min) begin
                            best_reg <= rd_cand;
                        end
                    end
                    if (pass_done) begin
                        iss_reg   <= '0;
                        state_reg <= SCAN_PICK;
                    end
                end
                SCAN_PICK: begin
                    if (rvld_reg && take_pick) begin
                        best_reg <= rd_cand;
                    end
                    if (pass_done) begin
                        state_reg <= EMIT;
                    end
                end
                EMIT: begin
                    // Hold the winner until the output register frees up.
                    if (out_free) begin
                        if (count_reg != '0) begin
                            m_data_reg.found                 <= 1'b1;
                            m_data_reg.chosen_kind           <= best_reg.kind;
                            m_data_reg.chosen_anchor         <= best_reg.anchor;
                            m_data_reg.chosen_priority       <= best_reg.prio;
                            m_data_reg.chosen_neighbor_valid <= best_reg.nbr_valid;
                            m_data_reg.chosen_neighbor_index <= best_reg.nbr_index;
                        end else begin
                            m_data_reg <= '0;
                        end
                        count_reg <= '0;
                        state_reg <= LOAD;
                    end
                end
                default: begin
                    state_reg <= LOAD;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/cwep_cand_mem.sv */
// Candidate store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module cwep_cand_mem (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [cwep_pkg::IDX_W-1:0] wr_addr,
    input  cwep_pkg::cand_t           wr_data,
    input  logic                      rd_en,
    input  logic [cwep_pkg::IDX_W-1:0] rd_addr,
    output cwep_pkg::cand_t           rd_data
);
    import cwep_pkg::*;

    cand_t mem [MAX_CANDIDATES];
    cand_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/cwep_checker.sv */
// Port-level checks for the contention window event picker, bound to the top level.
`timescale 1ns / 1ps

module cwep_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input cwep_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input cwep_pkg::out_item_t m_data
);
    import cwep_pkg::*;

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // An empty round reports all fields as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |->
            m_data.chosen_kind == 3'd0 && m_data.chosen_anchor == 64'd0 &&
            m_data.chosen_priority == 2'd0 && !m_data.chosen_neighbor_valid &&
            m_data.chosen_neighbor_index == 4'd0)
        else $error("not-found result carries data");

    // A winner never has an unwanted anchor and no slot without a neighbor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |->
            m_data.chosen_anchor != ANCHOR_NONE &&
            (m_data.chosen_neighbor_valid || m_data.chosen_neighbor_index == 4'd0))
        else $error("winner carries impossible fields");

    // The last item of a round starts selection; intake stops next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last |=> !s_ready)
        else $error("intake open during selection");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

bind contention_window_event_picker cwep_checker u_cwep_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
